FILE: rtl/core/oad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Obstacle avoidance drive package
// Shared widths, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package oad_pkg;

    localparam int unsigned DistW  = 16;
    localparam int unsigned SpeedW = 7;
    localparam int unsigned WheelW = 8;
    localparam int unsigned CmdW   = 8;
    localparam int unsigned ModeW  = 3;
    localparam int unsigned CfgIdxW = 8;

    // Remote-control command bytes.
    localparam logic [CmdW-1:0] CMD_NONE     = 8'h00;
    localparam logic [CmdW-1:0] CMD_FORWARD  = 8'h2A;
    localparam logic [CmdW-1:0] CMD_BACKWARD = 8'h27;
    localparam logic [CmdW-1:0] CMD_LEFT     = 8'h2B;
    localparam logic [CmdW-1:0] CMD_RIGHT    = 8'h28;
    localparam logic [CmdW-1:0] CMD_ONOFF    = 8'h30;

    typedef enum logic [ModeW-1:0] {
        MODE_OFF      = 3'd0,
        MODE_FORWARD  = 3'd1,
        MODE_BACKWARD = 3'd2,
        MODE_TLEFT    = 3'd3,
        MODE_TRIGHT   = 3'd4
    } t_mode;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_FRONT_LIMIT      = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_LEFT_LIMIT       = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_RIGHT_LIMIT      = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_GROUND_LEFT_MIN  = 8'd3;
    localparam logic [CfgIdxW-1:0] REG_GROUND_RIGHT_MIN = 8'd4;
    localparam logic [CfgIdxW-1:0] REG_SPEED_FORWARD    = 8'd5;
    localparam logic [CfgIdxW-1:0] REG_SPEED_BACKWARD   = 8'd6;
    localparam logic [CfgIdxW-1:0] REG_SPEED_TURN       = 8'd7;

    // Reset values.
    localparam logic [DistW-1:0]  RST_FRONT_LIMIT    = 16'h9000;
    localparam logic [DistW-1:0]  RST_SIDE_LIMIT     = 16'h8000;
    localparam logic [DistW-1:0]  RST_GROUND_MIN     = 16'h0000;
    localparam logic [SpeedW-1:0] RST_SPEED_FORWARD  = 7'd20;
    localparam logic [SpeedW-1:0] RST_SPEED_BACKWARD = 7'd15;
    localparam logic [SpeedW-1:0] RST_SPEED_TURN     = 7'd10;

endpackage
`default_nettype wire

FILE: rtl/core/obstacle_avoid_drive_fsm_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Obstacle avoidance drive state machine
// Obstacle flags, remote command latch and drive mode update with wheel speeds.
// ----------------------------------------------------------------------------
// Each accepted request is one sensor tick. It is captured in an input
// register, and once the result register is free the obstacle compares, the
// remote command latch and the drive mode update are evaluated in one pass and
// written into the result register, at which point the held distances,
// remote word, latched command and mode are also updated. A request is
// accepted every cycle while results are taken; each result is held in the
// result register until it is taken. The result register only holds back the
// input stage when a result is waiting and the downstream side is not ready.
// Configuration writes are always accepted and take effect on the next cycle;
// they should only be issued while the block holds no request in flight.
// ----------------------------------------------------------------------------
module obstacle_avoid_drive_fsm_top
    import oad_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [DistW-1:0]     i_cfg_data,

    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_sensor_fresh,
    input  wire logic [DistW-1:0]     i_dist_left_mid,
    input  wire logic [DistW-1:0]     i_dist_center,
    input  wire logic [DistW-1:0]     i_dist_right_mid,
    input  wire logic [DistW-1:0]     i_remote_code,
    input  wire logic [DistW-1:0]     i_floor_left,
    input  wire logic [DistW-1:0]     i_floor_right,

    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [ModeW-1:0]          o_mode,
    output logic                      o_mode_changed,
    output logic signed [WheelW-1:0]  o_left_wheel_speed,
    output logic signed [WheelW-1:0]  o_right_wheel_speed,
    output logic                      o_blocked_front,
    output logic                      o_blocked_left,
    output logic                      o_blocked_right
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [DistW-1:0]  r_front_limit;
    logic [DistW-1:0]  r_left_limit;
    logic [DistW-1:0]  r_right_limit;
    logic [DistW-1:0]  r_ground_left_min;
    logic [DistW-1:0]  r_ground_right_min;
    logic [SpeedW-1:0] r_speed_forward;
    logic [SpeedW-1:0] r_speed_backward;
    logic [SpeedW-1:0] r_speed_turn;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_limit      <= RST_FRONT_LIMIT;
            r_left_limit       <= RST_SIDE_LIMIT;
            r_right_limit      <= RST_SIDE_LIMIT;
            r_ground_left_min  <= RST_GROUND_MIN;
            r_ground_right_min <= RST_GROUND_MIN;
            r_speed_forward    <= RST_SPEED_FORWARD;
            r_speed_backward   <= RST_SPEED_BACKWARD;
            r_speed_turn       <= RST_SPEED_TURN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRONT_LIMIT:      r_front_limit      <= i_cfg_data;
                REG_LEFT_LIMIT:       r_left_limit       <= i_cfg_data;
                REG_RIGHT_LIMIT:      r_right_limit      <= i_cfg_data;
                REG_GROUND_LEFT_MIN:  r_ground_left_min  <= i_cfg_data;
                REG_GROUND_RIGHT_MIN: r_ground_right_min <= i_cfg_data;
                REG_SPEED_FORWARD:    r_speed_forward    <= i_cfg_data[SpeedW-1:0];
                REG_SPEED_BACKWARD:   r_speed_backward   <= i_cfg_data[SpeedW-1:0];
                REG_SPEED_TURN:       r_speed_turn       <= i_cfg_data[SpeedW-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. The stage advances whenever the result register is
    // empty or its content is being taken in this cycle.
    // ------------------------------------------------------------------
    logic             r_in_valid;
    logic             r_in_fresh;
    logic [DistW-1:0] r_in_left_mid;
    logic [DistW-1:0] r_in_center;
    logic [DistW-1:0] r_in_right_mid;
    logic [DistW-1:0] r_in_remote;
    logic [DistW-1:0] r_in_floor_left;
    logic [DistW-1:0] r_in_floor_right;

    logic out_free;
    logic advance;

    assign out_free = !o_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_fresh       <= i_sensor_fresh;
            r_in_left_mid    <= i_dist_left_mid;
            r_in_center      <= i_dist_center;
            r_in_right_mid   <= i_dist_right_mid;
            r_in_remote      <= i_remote_code;
            r_in_floor_left  <= i_floor_left;
            r_in_floor_right <= i_floor_right;
        end
    end

    // ------------------------------------------------------------------
    // Block state, updated when an item leaves the input register.
    // ------------------------------------------------------------------
    logic [DistW-1:0] r_held_left_mid;
    logic [DistW-1:0] r_held_center;
    logic [DistW-1:0] r_held_right_mid;
    logic [DistW-1:0] r_prev_remote;
    logic [CmdW-1:0]  r_latched_cmd;
    t_mode            r_mode;

    logic [DistW-1:0] n_held_left_mid;
    logic [DistW-1:0] n_held_center;
    logic [DistW-1:0] n_held_right_mid;
    logic [DistW-1:0] n_prev_remote;
    logic [CmdW-1:0]  n_latched_cmd;
    t_mode            n_mode;

    logic ob_front;
    logic ob_left;
    logic ob_right;
    logic ob_all;
    logic handled;
    logic [CmdW-1:0] cmd_seen;

    logic signed [WheelW-1:0] n_left_speed;
    logic signed [WheelW-1:0] n_right_speed;

    always_comb begin
        n_held_left_mid  = r_held_left_mid;
        n_held_center    = r_held_center;
        n_held_right_mid = r_held_right_mid;
        n_prev_remote    = r_prev_remote;
        cmd_seen         = r_latched_cmd;
        // A fresh tick refreshes the distances; a new remote word latches.
        if (r_in_fresh) begin
            n_held_left_mid  = r_in_left_mid;
            n_held_center    = r_in_center;
            n_held_right_mid = r_in_right_mid;
            if (r_in_remote != r_prev_remote) begin
                cmd_seen      = r_in_remote[CmdW-1:0];
                n_prev_remote = r_in_remote;
            end
        end
    end

    // Obstacle flags. When something is ahead, the side reading that is
    // nearer decides which side counts as blocked.
    assign ob_front = n_held_center > r_front_limit;
    assign ob_left  = (n_held_left_mid > r_left_limit)
                   || (r_in_floor_left < r_ground_left_min)
                   || (ob_front && (n_held_left_mid >= n_held_right_mid));
    assign ob_right = (n_held_right_mid > r_right_limit)
                   || (r_in_floor_right < r_ground_right_min)
                   || (ob_front && (n_held_left_mid < n_held_right_mid));
    assign ob_all   = ob_left && ob_right && ob_front;

    always_comb begin
        n_mode        = r_mode;
        n_latched_cmd = cmd_seen;
        handled       = 1'b1;
        // Remote commands take priority; on-off is one-shot, drive codes
        // stay in force while latched.
        unique case (cmd_seen)
            CMD_ONOFF: begin
                n_mode        = (r_mode == MODE_OFF) ? MODE_FORWARD : MODE_OFF;
                n_latched_cmd = CMD_NONE;
            end
            CMD_FORWARD:  n_mode = MODE_FORWARD;
            CMD_BACKWARD: n_mode = MODE_BACKWARD;
            CMD_LEFT:     n_mode = MODE_TLEFT;
            CMD_RIGHT:    n_mode = MODE_TRIGHT;
            default:      handled = 1'b0;
        endcase

        if (!handled) begin
            unique case (r_mode)
                MODE_FORWARD: begin
                    if (ob_all) begin
                        n_mode = MODE_BACKWARD;
                    end else if (ob_left) begin
                        n_mode = MODE_TRIGHT;
                    end else if (ob_right) begin
                        n_mode = MODE_TLEFT;
                    end
                end
                MODE_BACKWARD: begin
                    if (!ob_left) begin
                        n_mode = MODE_TLEFT;
                    end else if (!ob_right) begin
                        n_mode = MODE_TRIGHT;
                    end
                end
                MODE_TLEFT: begin
                    if (!(ob_left || ob_right || ob_front)) begin
                        n_mode = MODE_FORWARD;
                    end else if (ob_left) begin
                        n_mode = MODE_BACKWARD;
                    end
                end
                MODE_TRIGHT: begin
                    if (!(ob_left || ob_right || ob_front)) begin
                        n_mode = MODE_FORWARD;
                    end else if (ob_right) begin
                        n_mode = MODE_BACKWARD;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Wheel speeds from the new mode.
    always_comb begin
        n_left_speed  = '0;
        n_right_speed = '0;
        unique case (n_mode)
            MODE_FORWARD: begin
                n_left_speed  = $signed({1'b0, r_speed_forward});
                n_right_speed = $signed({1'b0, r_speed_forward});
            end
            MODE_BACKWARD: begin
                n_left_speed  = -$signed({1'b0, r_speed_backward});
                n_right_speed = -$signed({1'b0, r_speed_backward});
            end
            MODE_TLEFT: begin
                n_left_speed  = -$signed({1'b0, r_speed_turn});
                n_right_speed = $signed({1'b0, r_speed_turn});
            end
            MODE_TRIGHT: begin
                n_left_speed  = $signed({1'b0, r_speed_turn});
                n_right_speed = -$signed({1'b0, r_speed_turn});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_left_mid  <= '0;
            r_held_center    <= '0;
            r_held_right_mid <= '0;
            r_prev_remote    <= '0;
            r_latched_cmd    <= CMD_NONE;
            r_mode           <= MODE_OFF;
        end else if (advance) begin
            r_held_left_mid  <= n_held_left_mid;
            r_held_center    <= n_held_center;
            r_held_right_mid <= n_held_right_mid;
            r_prev_remote    <= n_prev_remote;
            r_latched_cmd    <= n_latched_cmd;
            r_mode           <= n_mode;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_free) begin
            o_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_mode              <= n_mode;
            o_mode_changed      <= (n_mode != r_mode);
            o_left_wheel_speed  <= n_left_speed;
            o_right_wheel_speed <= n_right_speed;
            o_blocked_front     <= ob_front;
            o_blocked_left      <= ob_left;
            o_blocked_right     <= ob_right;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mode <= MODE_TRIGHT))
        else $error("result mode out of range");

    a_off_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mode == MODE_OFF) |->
            (o_left_wheel_speed == '0 && o_right_wheel_speed == '0))
        else $error("wheels turning while off");

    a_turn_opposed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_mode == MODE_TLEFT || o_mode == MODE_TRIGHT)) |->
            (o_left_wheel_speed == -o_right_wheel_speed))
        else $error("turn speeds not opposed");

    a_mode_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(advance) |-> (o_mode == r_mode))
        else $error("result mode differs from stored mode");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Obstacle avoidance drive state machine testbench
// Drives sensor-tick requests and register writes into the block and checks
// every result field against a typed result or a cycle-free model of the drive mode logic.
// ----------------------------------------------------------------------------
// A short directed table comes first. Most of its rows carry a result typed
// in by hand; the rest are checked against the model. Random phases follow,
// each with its own register setting and its own mix of sender gaps and
// receiver stalls. A final phase holds the receiver off for a long stretch so
// that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top
    import oad_pkg::*;
();

    localparam int CLK_HALF         = 6;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 360;
    localparam int RANDOM_PHASES    = 5;
    localparam int PRESSURE_TICKS   = 60;

    // One sensor tick as it is presented to the block.
    typedef struct packed {
        logic             fresh;
        logic [DistW-1:0] left_mid;
        logic [DistW-1:0] centre;
        logic [DistW-1:0] right_mid;
        logic [DistW-1:0] remote;
        logic [DistW-1:0] floor_l;
        logic [DistW-1:0] floor_r;
    } t_tick;

    // One drive result: mode, change flag, wheel speeds and obstacle flags.
    typedef struct packed {
        t_mode             mode;
        logic              changed;
        logic [WheelW-1:0] left_spd;
        logic [WheelW-1:0] right_spd;
        logic              blk_front;
        logic              blk_left;
        logic              blk_right;
    } t_drive_result;

    typedef struct packed {
        t_tick         tk;
        logic          typed;
        t_drive_result res;
    } t_plan_row;

    // ------------------------------------------------------------------------
    // Signals towards and from the block. Everything the bench drives starts
    // at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_valid      = 1'b0;
    logic [CfgIdxW-1:0]    i_cfg_index      = '0;
    logic [DistW-1:0]      i_cfg_data       = '0;
    logic                  i_valid          = 1'b0;
    logic                  i_sensor_fresh   = 1'b0;
    logic [DistW-1:0]      i_dist_left_mid  = '0;
    logic [DistW-1:0]      i_dist_center    = '0;
    logic [DistW-1:0]      i_dist_right_mid = '0;
    logic [DistW-1:0]      i_remote_code    = '0;
    logic [DistW-1:0]      i_floor_left     = '0;
    logic [DistW-1:0]      i_floor_right    = '0;
    logic                  i_ready          = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_ready;
    logic                  o_valid;
    logic [ModeW-1:0]      o_mode;
    logic                  o_mode_changed;
    logic signed [WheelW-1:0] o_left_wheel_speed;
    logic signed [WheelW-1:0] o_right_wheel_speed;
    logic                  o_blocked_front;
    logic                  o_blocked_left;
    logic                  o_blocked_right;

    // A hand-typed result travels with its request so that the monitor can
    // queue it in place of the modelled one.
    logic                  tick_typed       = 1'b0;
    t_drive_result         tick_typed_res   = '0;

    obstacle_avoid_drive_fsm_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sensor_fresh      (i_sensor_fresh),
        .i_dist_left_mid     (i_dist_left_mid),
        .i_dist_center       (i_dist_center),
        .i_dist_right_mid    (i_dist_right_mid),
        .i_remote_code       (i_remote_code),
        .i_floor_left        (i_floor_left),
        .i_floor_right       (i_floor_right),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_mode              (o_mode),
        .o_mode_changed      (o_mode_changed),
        .o_left_wheel_speed  (o_left_wheel_speed),
        .o_right_wheel_speed (o_right_wheel_speed),
        .o_blocked_front     (o_blocked_front),
        .o_blocked_left      (o_blocked_left),
        .o_blocked_right     (o_blocked_right)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Model state: the bench's own copy of the registers and of the drive
    // state, advanced once per accepted request.
    // ------------------------------------------------------------------------
    logic [DistW-1:0]  lim_front, lim_left, lim_right;
    logic [DistW-1:0]  floor_min_l, floor_min_r;
    logic [SpeedW-1:0] spd_fwd, spd_back, spd_turn;
    logic [DistW-1:0]  kept_left, kept_centre, kept_right;
    logic [DistW-1:0]  last_remote;
    logic [CmdW-1:0]   cmd_latch;
    t_mode             cur_mode;

    t_drive_result     pending_drive[$];
    t_plan_row         plan[$];

    // Remote word that the random stream currently repeats.
    logic [DistW-1:0]  stream_remote   = '0;

    int                send_idle_pct   = 0;
    int                recv_stall_pct  = 0;
    bit                long_hold_req   = 1'b0;
    int                hold_left       = 0;

    int                fail_count      = 0;
    int                cycle_count     = 0;
    int                results_checked = 0;
    int                reg_writes      = 0;
    int                mode_changes    = 0;
    int                mode_hits [0:7] = '{default: 0};

    // Works out the result of one sensor tick and moves the model state on.
    function automatic t_drive_result predict_drive(input t_tick t);
        t_drive_result r;
        t_mode         nxt;
        logic          ob_f, ob_l, ob_r, ob_all, forced;

        nxt = cur_mode;
        if (t.fresh) begin
            kept_left   = t.left_mid;
            kept_centre = t.centre;
            kept_right  = t.right_mid;
            if (t.remote != last_remote) begin
                cmd_latch   = t.remote[CmdW-1:0];
                last_remote = t.remote;
            end
        end

        ob_f   = kept_centre > lim_front;
        ob_l   = (kept_left > lim_left) || (t.floor_l < floor_min_l) ||
                 (ob_f && (kept_left >= kept_right));
        ob_r   = (kept_right > lim_right) || (t.floor_r < floor_min_r) ||
                 (ob_f && (kept_left < kept_right));
        ob_all = ob_f && ob_l && ob_r;

        // A latched drive code wins over avoidance; on-off is used up at once.
        forced = 1'b1;
        case (cmd_latch)
            CMD_ONOFF: begin
                nxt       = (nxt == MODE_OFF) ? MODE_FORWARD : MODE_OFF;
                cmd_latch = CMD_NONE;
            end
            CMD_FORWARD:  nxt = MODE_FORWARD;
            CMD_BACKWARD: nxt = MODE_BACKWARD;
            CMD_LEFT:     nxt = MODE_TLEFT;
            CMD_RIGHT:    nxt = MODE_TRIGHT;
            default:      forced = 1'b0;
        endcase

        if (!forced) begin
            case (nxt)
                MODE_FORWARD: begin
                    if (ob_all) nxt = MODE_BACKWARD;
                    else if (ob_l) nxt = MODE_TRIGHT;
                    else if (ob_r) nxt = MODE_TLEFT;
                end
                MODE_BACKWARD: begin
                    if (!ob_l) nxt = MODE_TLEFT;
                    else if (!ob_r) nxt = MODE_TRIGHT;
                end
                MODE_TLEFT: begin
                    if (!(ob_l || ob_r || ob_f)) nxt = MODE_FORWARD;
                    else if (ob_l) nxt = MODE_BACKWARD;
                end
                MODE_TRIGHT: begin
                    if (!(ob_l || ob_r || ob_f)) nxt = MODE_FORWARD;
                    else if (ob_r) nxt = MODE_BACKWARD;
                end
                default: ;
            endcase
        end

        r.mode      = nxt;
        r.changed   = (nxt != cur_mode);
        r.blk_front = ob_f;
        r.blk_left  = ob_l;
        r.blk_right = ob_r;
        case (nxt)
            MODE_FORWARD: begin
                r.left_spd  = {1'b0, spd_fwd};
                r.right_spd = {1'b0, spd_fwd};
            end
            MODE_BACKWARD: begin
                r.left_spd  = -{1'b0, spd_back};
                r.right_spd = -{1'b0, spd_back};
            end
            MODE_TLEFT: begin
                r.left_spd  = -{1'b0, spd_turn};
                r.right_spd = {1'b0, spd_turn};
            end
            MODE_TRIGHT: begin
                r.left_spd  = {1'b0, spd_turn};
                r.right_spd = -{1'b0, spd_turn};
            end
            default: begin
                r.left_spd  = '0;
                r.right_spd = '0;
            end
        endcase
        cur_mode = nxt;
        return r;
    endfunction

    // Values close to a threshold make the compares flip often; the rest
    // spread over the whole range and its ends.
    function automatic logic [DistW-1:0] around_threshold(input logic [DistW-1:0] mark);
        int v;

        case ($urandom_range(9))
            0, 1, 2, 3: begin
                v = int'(mark) + int'($urandom_range(4)) - 2;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
            4, 5, 6: v = $urandom_range(65535);
            7:       v = 0;
            8:       v = 65535;
            default: v = int'(mark);
        endcase
        return v[DistW-1:0];
    endfunction

    // Random tick. Fresh ticks mostly repeat the current remote word and now
    // and then bring a new one; stale ticks carry junk that must be ignored.
    function automatic t_tick compose_tick();
        t_tick           t;
        logic [CmdW-1:0] cmd;

        t.fresh = ($urandom_range(99) < 80);
        if (t.fresh) begin
            t.left_mid  = around_threshold(lim_left);
            t.centre    = around_threshold(lim_front);
            t.right_mid = around_threshold(lim_right);
            if ($urandom_range(99) < 12) begin
                case ($urandom_range(9))
                    0, 1, 2: cmd = CMD_ONOFF;
                    3:       cmd = CMD_FORWARD;
                    4:       cmd = CMD_BACKWARD;
                    5:       cmd = CMD_LEFT;
                    6:       cmd = CMD_RIGHT;
                    7:       cmd = CMD_NONE;
                    default: cmd = CmdW'($urandom_range(255));
                endcase
                t.remote = {8'($urandom_range(255)), cmd};
                if (t.remote == stream_remote) t.remote ^= 16'h0100;
                stream_remote = t.remote;
            end else begin
                t.remote = stream_remote;
            end
        end else begin
            t.left_mid  = DistW'($urandom);
            t.centre    = DistW'($urandom);
            t.right_mid = DistW'($urandom);
            t.remote    = DistW'($urandom);
        end
        t.floor_l = around_threshold(floor_min_l);
        t.floor_r = around_threshold(floor_min_r);
        return t;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Offers one request. An optional gap goes first, so that valid is never
    // dropped and raised again within one time step.
    task automatic send_tick(input t_tick t, input logic typed, input t_drive_result tres);
        int gap;

        gap = 0;
        while (gap < 200 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_sensor_fresh   <= t.fresh;
        i_dist_left_mid  <= t.left_mid;
        i_dist_center    <= t.centre;
        i_dist_right_mid <= t.right_mid;
        i_remote_code    <= t.remote;
        i_floor_left     <= t.floor_l;
        i_floor_right    <= t.floor_r;
        tick_typed       <= typed;
        tick_typed_res   <= tres;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic add_row(input logic fr, input logic [DistW-1:0] dl, dc, dr, rc, fll, flr,
                           input logic typed, input t_mode m, input logic chg,
                           input logic [7:0] ls, rs, input logic [2:0] flags);
        t_plan_row row;

        row.tk  = '{fresh: fr, left_mid: dl, centre: dc, right_mid: dr,
                    remote: rc, floor_l: fll, floor_r: flr};
        row.typed = typed;
        row.res = '{mode: m, changed: chg, left_spd: ls, right_spd: rs,
                    blk_front: flags[2], blk_left: flags[1], blk_right: flags[0]};
        plan.push_back(row);
    endtask

    task automatic send_plan();
        foreach (plan[k]) send_tick(plan[k].tk, plan[k].typed, plan[k].res);
        plan.delete();
    endtask

    // Waits until every queued result has come back, then lets the pipeline
    // settle so that a register write lands on an idle block.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [DistW-1:0] fr, lt, rt, gl, gr, sf, sb, st);
        logic [CfgIdxW-1:0] idx [8];
        logic [DistW-1:0]   val [8];
        int                 k;

        idx[0] = REG_FRONT_LIMIT;      val[0] = fr;
        idx[1] = REG_LEFT_LIMIT;       val[1] = lt;
        idx[2] = REG_RIGHT_LIMIT;      val[2] = rt;
        idx[3] = REG_GROUND_LEFT_MIN;  val[3] = gl;
        idx[4] = REG_GROUND_RIGHT_MIN; val[4] = gr;
        idx[5] = REG_SPEED_FORWARD;    val[5] = sf;
        idx[6] = REG_SPEED_BACKWARD;   val[6] = sb;
        idx[7] = REG_SPEED_TURN;       val[7] = st;
        for (k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Ready is redrawn every cycle from the current stall rate. A
    // long hold-off, once requested, is counted down here on its own.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD_CYCLES - 1;
            i_ready      <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. All handshakes are sampled at the rising edge, before any of
    // this edge's updates land. Results are checked before new requests are
    // queued, so a stray result can never match a request of the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_drive_result want;
        t_drive_result calc;
        t_tick         tk;

        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_drive.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    want = pending_drive.pop_front();
                    check_field("mode", 8'(want.mode), 8'(o_mode));
                    check_field("mode_changed", 8'(want.changed), 8'(o_mode_changed));
                    check_field("left_wheel_speed", want.left_spd, o_left_wheel_speed);
                    check_field("right_wheel_speed", want.right_spd, o_right_wheel_speed);
                    check_field("blocked_front", 8'(want.blk_front), 8'(o_blocked_front));
                    check_field("blocked_left", 8'(want.blk_left), 8'(o_blocked_left));
                    check_field("blocked_right", 8'(want.blk_right), 8'(o_blocked_right));
                    results_checked++;
                    mode_hits[o_mode]++;
                    if (o_mode_changed) mode_changes++;
                end
            end

            if (i_valid && o_ready) begin
                tk = '{fresh: i_sensor_fresh, left_mid: i_dist_left_mid,
                       centre: i_dist_center, right_mid: i_dist_right_mid,
                       remote: i_remote_code, floor_l: i_floor_left,
                       floor_r: i_floor_right};
                calc = predict_drive(tk);
                pending_drive.push_back(tick_typed ? tick_typed_res : calc);
            end

            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    REG_FRONT_LIMIT:      lim_front   = i_cfg_data;
                    REG_LEFT_LIMIT:       lim_left    = i_cfg_data;
                    REG_RIGHT_LIMIT:      lim_right   = i_cfg_data;
                    REG_GROUND_LEFT_MIN:  floor_min_l = i_cfg_data;
                    REG_GROUND_RIGHT_MIN: floor_min_r = i_cfg_data;
                    REG_SPEED_FORWARD:    spd_fwd     = i_cfg_data[SpeedW-1:0];
                    REG_SPEED_BACKWARD:   spd_back    = i_cfg_data[SpeedW-1:0];
                    REG_SPEED_TURN:       spd_turn    = i_cfg_data[SpeedW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int p;

        lim_front   = RST_FRONT_LIMIT;
        lim_left    = RST_SIDE_LIMIT;
        lim_right   = RST_SIDE_LIMIT;
        floor_min_l = RST_GROUND_MIN;
        floor_min_r = RST_GROUND_MIN;
        spd_fwd     = RST_SPEED_FORWARD;
        spd_back    = RST_SPEED_BACKWARD;
        spd_turn    = RST_SPEED_TURN;
        kept_left   = '0;
        kept_centre = '0;
        kept_right  = '0;
        last_remote = '0;
        cmd_latch   = CMD_NONE;
        cur_mode    = MODE_OFF;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset settings. The typed results follow the
        // mode through its transitions by hand; speeds are 20, -15 and +/-10.
        // A stale tick with nothing latched leaves the block off.
        add_row(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                1'b1, MODE_OFF, 1'b0, 8'h00, 8'h00, 3'b000);
        // On-off switches the robot on.
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0030, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_FORWARD, 1'b1, 8'h14, 8'h14, 3'b000);
        // All readings at full scale: everything blocked, so it backs up.
        add_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0030, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_BACKWARD, 1'b1, 8'hF1, 8'hF1, 3'b111);
        // Stale tick: junk distances and remote word must be ignored.
        add_row(1'b0, 16'h5A5A, 16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'h0000,
                1'b1, MODE_BACKWARD, 1'b0, 8'hF1, 8'hF1, 3'b111);
        add_row(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0030, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_TRIGHT, 1'b1, 8'h0A, 8'hF6, 3'b010);
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0030, 16'hFFFF, 16'h0000,
                1'b1, MODE_FORWARD, 1'b1, 8'h14, 8'h14, 3'b000);
        add_row(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0030, 16'h0000, 16'hFFFF,
                1'b1, MODE_TLEFT, 1'b1, 8'hF6, 8'h0A, 3'b101);
        // Readings exactly at the limits do not count as obstacles.
        add_row(1'b1, 16'h8000, 16'h9000, 16'h8000, 16'h0030, 16'h8000, 16'h8000,
                1'b1, MODE_FORWARD, 1'b1, 8'h14, 8'h14, 3'b000);
        add_row(1'b1, 16'h8001, 16'h9001, 16'h8001, 16'h0030, 16'h0001, 16'h0001,
                1'b1, MODE_BACKWARD, 1'b1, 8'hF1, 8'hF1, 3'b111);
        // Backward drive code with noise in the high byte, then held on a
        // stale tick even though avoidance would turn.
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hAB27, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_BACKWARD, 1'b0, 8'hF1, 8'hF1, 3'b000);
        add_row(1'b0, 16'hA5A5, 16'hA5A5, 16'hA5A5, 16'h0000, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_BACKWARD, 1'b0, 8'hF1, 8'hF1, 3'b000);
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h002A, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_FORWARD, 1'b1, 8'h14, 8'h14, 3'b000);
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h012B, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_TLEFT, 1'b1, 8'hF6, 8'h0A, 3'b000);
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0028, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_TRIGHT, 1'b1, 8'h0A, 8'hF6, 3'b000);
        // Unknown command stays latched but avoidance carries on.
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0055, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_FORWARD, 1'b1, 8'h14, 8'h14, 3'b000);
        add_row(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0055, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_TRIGHT, 1'b1, 8'h0A, 8'hF6, 3'b010);
        // On-off with a new high byte switches off; the repeated word keeps
        // the block off even with everything blocked.
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFF30, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_OFF, 1'b1, 8'h00, 8'h00, 3'b000);
        add_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF30, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_OFF, 1'b0, 8'h00, 8'h00, 3'b111);
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0030, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_FORWARD, 1'b1, 8'h14, 8'h14, 3'b000);
        // Obstacle ahead with equal side readings leans on the left flag,
        // one count more on the right moves it to the right flag.
        add_row(1'b1, 16'h1000, 16'hFFFF, 16'h1000, 16'h0030, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_TRIGHT, 1'b1, 8'h0A, 8'hF6, 3'b110);
        add_row(1'b1, 16'h1000, 16'hFFFF, 16'h1001, 16'h0030, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_BACKWARD, 1'b1, 8'hF1, 8'hF1, 3'b101);
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0030, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_TLEFT, 1'b1, 8'hF6, 8'h0A, 3'b000);
        add_row(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0030, 16'hFFFF, 16'hFFFF,
                1'b1, MODE_BACKWARD, 1'b1, 8'hF1, 8'hF1, 3'b010);
        send_plan();
        wait_idle();

        // Lowest limits, highest floor minimums and full speed: the floor
        // edge compares now matter. These rows are left to the model.
        program_regs(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                     16'h007F, 16'h007F, 16'h007F);
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0030, 16'h0000, 16'hFFFF,
                1'b0, MODE_OFF, 1'b0, 8'h00, 8'h00, 3'b000);
        add_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h1130, 16'hFFFF, 16'h0000,
                1'b0, MODE_OFF, 1'b0, 8'h00, 8'h00, 3'b000);
        add_row(1'b1, 16'h0001, 16'h0001, 16'h0001, 16'h112A, 16'hFFFF, 16'hFFFF,
                1'b0, MODE_OFF, 1'b0, 8'h00, 8'h00, 3'b000);
        send_plan();
        wait_idle();

        // Highest limits, zero floor minimums and zero speeds.
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000, 16'h0000);
        add_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0077, 16'h0000, 16'h0000,
                1'b0, MODE_OFF, 1'b0, 8'h00, 8'h00, 3'b000);
        add_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0030, 16'h0000, 16'h0000,
                1'b0, MODE_OFF, 1'b0, 8'h00, 8'h00, 3'b000);
        send_plan();
        wait_idle();

        // Random phases, each with its own register setting and flow control.
        stream_remote = last_remote;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    program_regs(RST_FRONT_LIMIT, RST_SIDE_LIMIT, RST_SIDE_LIMIT,
                                 16'h0000, 16'h0000, 16'd20, 16'd15, 16'd10);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    // Upper data bits on the speed registers must be dropped.
                    program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom_range(16'h2000)), 16'($urandom_range(16'h2000)),
                                 16'($urandom), 16'($urandom), 16'($urandom));
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000,
                                 16'h007F, 16'h0000, 16'h007F);
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                3: begin
                    program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom_range(16'h4000)), 16'($urandom_range(16'h4000)),
                                 16'($urandom_range(127)), 16'($urandom_range(127)),
                                 16'($urandom_range(127)));
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
                default: begin
                    program_regs(16'h4000, 16'h3000, 16'h5000, 16'h0100, 16'h0080,
                                 16'd1, 16'd127, 16'd64);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_tick(compose_tick(), 1'b0, '0);
            wait_idle();
        end

        // Back-pressure: the receiver holds off for a long stretch while
        // requests keep coming, so the block fills and drops o_ready.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b1;
        repeat (PRESSURE_TICKS) send_tick(compose_tick(), 1'b0, '0);
        wait_idle();

        $display("Summary: %0d ticks checked, %0d register writes, %0d mode changes.",
                 results_checked, reg_writes, mode_changes);
        $display("Summary: results per mode off/fwd/back/left/right %0d/%0d/%0d/%0d/%0d.",
                 mode_hits[MODE_OFF], mode_hits[MODE_FORWARD], mode_hits[MODE_BACKWARD],
                 mode_hits[MODE_TLEFT], mode_hits[MODE_TRIGHT]);
        if (fail_count == 0 && pending_drive.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
